@@ rtl/i2cm_pkg.sv @@
// Shared types and codes for the I2C register-transfer master.
`default_nettype none

package i2cm_pkg;

    // Commands carried by an input beat
    localparam logic [2:0] CMD_TICK  = 3'd0;
    localparam logic [2:0] CMD_WRITE = 3'd1;
    localparam logic [2:0] CMD_READ  = 3'd2;
    localparam logic [2:0] CMD_PROBE = 3'd3;
    localparam logic [2:0] CMD_DATA  = 3'd4;

    // Bus sequencer phases
    localparam logic [4:0] PH_IDLE       = 5'd0;
    localparam logic [4:0] PH_PRESTOP    = 5'd1;
    localparam logic [4:0] PH_START_A    = 5'd2;
    localparam logic [4:0] PH_START_B    = 5'd3;
    localparam logic [4:0] PH_START_C    = 5'd4;
    localparam logic [4:0] PH_SEND_SETUP = 5'd5;
    localparam logic [4:0] PH_SEND_HIGH  = 5'd6;
    localparam logic [4:0] PH_SEND_LOW   = 5'd7;
    localparam logic [4:0] PH_ACK_REL    = 5'd8;
    localparam logic [4:0] PH_ACK_HIGH   = 5'd9;
    localparam logic [4:0] PH_ACK_LOW    = 5'd10;
    localparam logic [4:0] PH_WAIT_DATA  = 5'd11;
    localparam logic [4:0] PH_RECV_HIGH  = 5'd12;
    localparam logic [4:0] PH_RECV_LOW   = 5'd13;
    localparam logic [4:0] PH_MACK_SET   = 5'd14;
    localparam logic [4:0] PH_MACK_HIGH  = 5'd15;
    localparam logic [4:0] PH_MACK_LOW   = 5'd16;
    localparam logic [4:0] PH_STOP       = 5'd17;

    // Transaction kinds
    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_PROBE = 2'd2;

    // Status codes
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_WR_ADDR    = 3'd1;
    localparam logic [2:0] ST_WR_REG     = 3'd2;
    localparam logic [2:0] ST_WR_DATA    = 3'd3;
    localparam logic [2:0] ST_RD_ADDR    = 3'd4;
    localparam logic [2:0] ST_RD_REG     = 3'd5;
    localparam logic [2:0] ST_RD_RADDR   = 3'd6;
    localparam logic [2:0] ST_ABSENT     = 3'd7;

    // Configuration register indexes
    localparam logic REG_DELAY_TICKS = 1'b0;

    localparam logic [7:0] DELAY_DEFAULT = 8'd4;

    // Sequencer state apart from the byte counter
    typedef struct packed {
        logic [4:0] phase;
        logic [2:0] bit_count;
        logic [7:0] shift_byte;
        logic [7:0] delay_count;
        logic [6:0] held_device;
        logic [7:0] held_register;
        logic [1:0] operation;
        logic       scl;
        logic       sda;
        logic [2:0] last_status;
    } seq_t;

    // One result beat
    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic [7:0] read_data;
        logic       read_valid;
        logic       read_last;
        logic       need_data;
        logic       busy_res;
        logic       done_res;
        logic [2:0] status;
    } res_t;

    localparam seq_t SEQ_RESET = '{
        phase: PH_IDLE, bit_count: 3'd0, shift_byte: 8'd0, delay_count: 8'd0,
        held_device: 7'd0, held_register: 8'd0, operation: OP_WRITE,
        scl: 1'b1, sda: 1'b1, last_status: ST_OK};

endpackage

`default_nettype wire

@@ rtl/i2c_master_register_transfer.sv @@
// A beat passes the input register, then the result register; a new one is taken while a result waits.
// Throughput: one beat per cycle unless both registers are full and out_ready is low.
// The sequencer state advances once per beat through a single pass of next-state logic.
// Reset (rst_n low, asynchronous): sequencer idle with SCL and SDA released and status zero,
// delay quantum 4, both registers empty; the result outputs themselves are not reset.
`default_nettype none

module i2c_master_register_transfer
    import i2cm_pkg::*;
#(
    parameter int LENGTH_BITS = 16
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [2:0]             paddr,
    input  wire logic [31:0]            pwdata,
    output logic      [31:0]            prdata,
    output logic                        pready,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic [2:0]             command,
    input  wire logic [6:0]             device_address,
    input  wire logic [7:0]             register_address,
    input  wire logic [LENGTH_BITS-1:0] length,
    input  wire logic [7:0]             write_data,
    input  wire logic                   sda_in,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic                        scl_out,
    output logic                        sda_out,
    output logic      [7:0]             read_data,
    output logic                        read_valid,
    output logic                        read_last,
    output logic                        need_data,
    output logic                        busy_res,
    output logic                        done_res,
    output logic      [2:0]             status
);

    logic [7:0]             delay_ticks;

    logic                   in_vld_reg;
    logic                   in_vld_next;
    logic [2:0]             cmd_reg;
    logic [6:0]             dev_reg;
    logic [7:0]             regaddr_reg;
    logic [LENGTH_BITS-1:0] len_reg;
    logic [7:0]             wdata_reg;
    logic                   sda_reg;

    seq_t                   st_reg;
    seq_t                   st_next;
    logic [LENGTH_BITS-1:0] bl_reg;
    logic [LENGTH_BITS-1:0] bl_next;

    logic                   out_vld_reg;
    logic                   out_vld_next;
    res_t                   res_reg;
    res_t                   res_next;

    logic                   in_take;
    logic                   step_en;

    i2cm_apb u_apb (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .delay_ticks (delay_ticks)
    );

    i2cm_step #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_step (
        .st               (st_reg),
        .bytes_left       (bl_reg),
        .delay_ticks      (delay_ticks),
        .command          (cmd_reg),
        .device_address   (dev_reg),
        .register_address (regaddr_reg),
        .length           (len_reg),
        .write_data       (wdata_reg),
        .sda_in           (sda_reg),
        .st_next          (st_next),
        .bytes_left_next  (bl_next),
        .res              (res_next)
    );

    // advance a held beat whenever the result slot is free or draining
    assign step_en  = in_vld_reg && (!out_vld_reg || out_ready);
    assign in_ready = !in_vld_reg || step_en;
    assign in_take  = in_valid && in_ready;

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (in_take)
            in_vld_next = 1'b1;
        else if (step_en)
            in_vld_next = 1'b0;

        out_vld_next = out_vld_reg;
        if (step_en)
            out_vld_next = 1'b1;
        else if (out_ready)
            out_vld_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            st_reg      <= SEQ_RESET;
            bl_reg      <= '0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
            if (step_en)
            begin
                st_reg <= st_next;
                bl_reg <= bl_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            cmd_reg     <= command;
            dev_reg     <= device_address;
            regaddr_reg <= register_address;
            len_reg     <= length;
            wdata_reg   <= write_data;
            sda_reg     <= sda_in;
        end
        if (step_en)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid  = out_vld_reg;
    assign scl_out    = res_reg.scl_out;
    assign sda_out    = res_reg.sda_out;
    assign read_data  = res_reg.read_data;
    assign read_valid = res_reg.read_valid;
    assign read_last  = res_reg.read_last;
    assign need_data  = res_reg.need_data;
    assign busy_res   = res_reg.busy_res;
    assign done_res   = res_reg.done_res;
    assign status     = res_reg.status;

    a_last_needs_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && read_last |-> read_valid)
        else $error("read_last without read_valid");

    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && done_res |-> !busy_res && !need_data)
        else $error("done while still busy");

    a_need_is_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && need_data |-> busy_res && !read_valid)
        else $error("need_data outside a write transfer");

    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> in_vld_reg && out_vld_reg && !out_ready)
        else $error("input stalled with free result slot");

    a_step_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
        step_en |=> out_valid)
        else $error("stepped beat lost");

endmodule

`default_nettype wire

@@ rtl/i2cm_apb.sv @@
// APB configuration port holding the bus delay quantum.
`default_nettype none

module i2cm_apb
    import i2cm_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    output logic      [7:0]  delay_ticks
);

    logic [7:0] delay_ticks_reg;
    logic [7:0] delay_ticks_next;
    logic       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_comb
    begin
        delay_ticks_next = delay_ticks_reg;
        if (wr_en && (paddr[2] == REG_DELAY_TICKS))
        begin
            delay_ticks_next = pwdata[7:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_ticks_reg <= DELAY_DEFAULT;
        end
        else
        begin
            delay_ticks_reg <= delay_ticks_next;
        end
    end

    always_comb
    begin
        prdata = 32'd0;
        if (paddr[2] == REG_DELAY_TICKS)
        begin
            prdata = {24'd0, delay_ticks_reg};
        end
    end

    assign delay_ticks = delay_ticks_reg;

endmodule

`default_nettype wire

@@ rtl/i2cm_step.sv @@
// Next-state and result logic of the bus sequencer for one input beat.
`default_nettype none

module i2cm_step
    import i2cm_pkg::*;
#(
    parameter int LENGTH_BITS = 16
)
(
    input  wire seq_t                   st,
    input  wire logic [LENGTH_BITS-1:0] bytes_left,
    input  wire logic [7:0]             delay_ticks,
    input  wire logic [2:0]             command,
    input  wire logic [6:0]             device_address,
    input  wire logic [7:0]             register_address,
    input  wire logic [LENGTH_BITS-1:0] length,
    input  wire logic [7:0]             write_data,
    input  wire logic                   sda_in,
    output seq_t                        st_next,
    output logic [LENGTH_BITS-1:0]      bytes_left_next,
    output res_t                        res
);

    logic [7:0]             dq;
    logic [7:0]             dev_w;
    logic [LENGTH_BITS-1:0] bl_dec;
    logic                   valid;
    logic                   last;
    logic                   done;
    seq_t                   n;
    logic [LENGTH_BITS-1:0] nbl;

    function automatic seq_t go_f(seq_t s, logic [4:0] ph, logic [7:0] d);
        s.phase       = ph;
        s.delay_count = d;
        return s;
    endfunction

    function automatic seq_t start_f(seq_t s, logic [7:0] d);
        s.sda = 1'b1;
        s.scl = 1'b1;
        return go_f(s, PH_START_A, d);
    endfunction

    function automatic seq_t stop_f(seq_t s, logic [7:0] d);
        s.sda = 1'b0;
        s.scl = 1'b1;
        return go_f(s, PH_STOP, d);
    endfunction

    function automatic seq_t send_f(seq_t s, logic [7:0] b, logic [2:0] code,
                                    logic [7:0] d);
        s.shift_byte  = b;
        s.bit_count   = 3'd0;
        s.last_status = code;
        s.sda         = b[7];
        return go_f(s, PH_SEND_SETUP, d);
    endfunction

    function automatic seq_t recv_f(seq_t s, logic [7:0] d);
        s.shift_byte = 8'd0;
        s.bit_count  = 3'd0;
        s.scl        = 1'b1;
        return go_f(s, PH_RECV_HIGH, d);
    endfunction

    assign dq     = (delay_ticks == 8'd0) ? 8'd1 : delay_ticks;
    assign dev_w  = {st.held_device, 1'b0};
    assign bl_dec = (bytes_left != '0) ? (bytes_left - LENGTH_BITS'(1)) : bytes_left;

    always_comb
    begin
        n     = st;
        nbl   = bytes_left;
        valid = 1'b0;
        last  = 1'b0;
        done  = 1'b0;
        case (command)
            CMD_WRITE, CMD_READ, CMD_PROBE:
            begin
                if (st.phase == PH_IDLE)
                begin
                    n.held_device   = device_address;
                    n.held_register = register_address;
                    nbl             = length;
                    n.bit_count     = 3'd0;
                    n.shift_byte    = 8'd0;
                    n.last_status   = ST_OK;
                    if (command == CMD_WRITE)
                    begin
                        n.operation = OP_WRITE;
                        n = start_f(n, dq);
                    end
                    else if (command == CMD_READ)
                    begin
                        n.operation = OP_READ;
                        n = start_f(n, dq);
                    end
                    else
                    begin
                        // probe opens with a stop to free the bus
                        n.operation = OP_PROBE;
                        n.sda = 1'b0;
                        n.scl = 1'b1;
                        n = go_f(n, PH_PRESTOP, dq);
                    end
                end
            end
            CMD_DATA:
            begin
                if (st.phase == PH_WAIT_DATA)
                begin
                    nbl = bl_dec;
                    n = send_f(n, write_data, ST_WR_DATA, dq);
                end
            end
            CMD_TICK:
            begin
                if ((st.phase != PH_IDLE) && (st.phase != PH_WAIT_DATA))
                begin
                    if (st.delay_count > 8'd1)
                    begin
                        n.delay_count = st.delay_count - 8'd1;
                    end
                    else
                    begin
                        case (st.phase)
                            PH_PRESTOP:
                            begin
                                n = start_f(n, dq);
                            end
                            PH_START_A:
                            begin
                                n.sda = 1'b0;
                                n = go_f(n, PH_START_B, dq);
                            end
                            PH_START_B:
                            begin
                                n.scl = 1'b0;
                                n = go_f(n, PH_START_C, dq);
                            end
                            PH_START_C:
                            begin
                                if (st.operation == OP_PROBE)
                                    n = send_f(n, dev_w, ST_ABSENT, dq);
                                else if (st.operation == OP_READ && st.last_status == ST_RD_REG)
                                    n = send_f(n, dev_w | 8'd1, ST_RD_RADDR, dq);
                                else if (st.operation == OP_READ)
                                    n = send_f(n, dev_w, ST_RD_ADDR, dq);
                                else
                                    n = send_f(n, dev_w, ST_WR_ADDR, dq);
                            end
                            PH_SEND_SETUP:
                            begin
                                n.scl = 1'b1;
                                n = go_f(n, PH_SEND_HIGH, dq);
                            end
                            PH_SEND_HIGH:
                            begin
                                n.scl = 1'b0;
                                if (st.bit_count == 3'd7)
                                    n.sda = 1'b1;
                                n.shift_byte = {st.shift_byte[6:0], 1'b0};
                                n = go_f(n, PH_SEND_LOW, dq);
                            end
                            PH_SEND_LOW:
                            begin
                                if (st.bit_count == 3'd7)
                                begin
                                    // release SDA for the slave's ack
                                    n.bit_count = 3'd0;
                                    n.sda = 1'b1;
                                    n = go_f(n, PH_ACK_REL, dq);
                                end
                                else
                                begin
                                    n.bit_count = st.bit_count + 3'd1;
                                    n.sda = st.shift_byte[7];
                                    n = go_f(n, PH_SEND_SETUP, dq);
                                end
                            end
                            PH_ACK_REL:
                            begin
                                n.scl = 1'b1;
                                n = go_f(n, PH_ACK_HIGH, dq);
                            end
                            PH_ACK_HIGH:
                            begin
                                n.shift_byte = {7'd0, sda_in};
                                n.scl = 1'b0;
                                n = go_f(n, PH_ACK_LOW, dq);
                            end
                            PH_ACK_LOW:
                            begin
                                if (st.shift_byte[0])
                                begin
                                    // nack: stop and keep the failing stage
                                    n = stop_f(n, dq);
                                end
                                else
                                begin
                                    case (st.last_status)
                                        ST_WR_ADDR:
                                            n = send_f(n, st.held_register, ST_WR_REG, dq);
                                        ST_RD_ADDR:
                                            n = send_f(n, st.held_register, ST_RD_REG, dq);
                                        ST_RD_REG:
                                            n = start_f(n, dq);
                                        ST_RD_RADDR:
                                        begin
                                            if (bytes_left == '0)
                                            begin
                                                n.last_status = ST_OK;
                                                n = stop_f(n, dq);
                                            end
                                            else
                                            begin
                                                n = recv_f(n, dq);
                                            end
                                        end
                                        ST_WR_REG, ST_WR_DATA:
                                        begin
                                            if (bytes_left == '0)
                                            begin
                                                n.last_status = ST_OK;
                                                n = stop_f(n, dq);
                                            end
                                            else
                                            begin
                                                n.last_status = ST_WR_DATA;
                                                n.phase = PH_WAIT_DATA;
                                                n.delay_count = 8'd0;
                                            end
                                        end
                                        default:
                                        begin
                                            n.last_status = ST_OK;
                                            n = stop_f(n, dq);
                                        end
                                    endcase
                                end
                            end
                            PH_RECV_HIGH:
                            begin
                                n.shift_byte = {st.shift_byte[6:0], sda_in};
                                n.scl = 1'b0;
                                n = go_f(n, PH_RECV_LOW, dq);
                            end
                            PH_RECV_LOW:
                            begin
                                if (st.bit_count == 3'd7)
                                begin
                                    // present the byte, nack only the final one
                                    n.bit_count = 3'd0;
                                    valid = 1'b1;
                                    last  = (bytes_left == LENGTH_BITS'(1));
                                    n.sda = last;
                                    n = go_f(n, PH_MACK_SET, dq);
                                end
                                else
                                begin
                                    n.bit_count = st.bit_count + 3'd1;
                                    n.scl = 1'b1;
                                    n = go_f(n, PH_RECV_HIGH, dq);
                                end
                            end
                            PH_MACK_SET:
                            begin
                                n.scl = 1'b1;
                                n = go_f(n, PH_MACK_HIGH, dq);
                            end
                            PH_MACK_HIGH:
                            begin
                                n.scl = 1'b0;
                                n = go_f(n, PH_MACK_LOW, dq);
                            end
                            PH_MACK_LOW:
                            begin
                                n.sda = 1'b1;
                                nbl = bl_dec;
                                if (bl_dec == '0)
                                begin
                                    n.last_status = ST_OK;
                                    n = stop_f(n, dq);
                                end
                                else
                                begin
                                    n = recv_f(n, dq);
                                end
                            end
                            PH_STOP:
                            begin
                                n.sda = 1'b1;
                                n.phase = PH_IDLE;
                                n.delay_count = 8'd0;
                                done = 1'b1;
                            end
                            default:
                            begin
                                n.phase = PH_IDLE;
                                n.delay_count = 8'd0;
                            end
                        endcase
                    end
                end
            end
            default:
            begin
                n = st;
            end
        endcase
    end

    assign st_next         = n;
    assign bytes_left_next = nbl;

    always_comb
    begin
        res.scl_out    = n.scl;
        res.sda_out    = n.sda;
        res.read_data  = valid ? n.shift_byte : 8'd0;
        res.read_valid = valid;
        res.read_last  = valid && last;
        res.need_data  = (n.phase == PH_WAIT_DATA);
        res.busy_res   = (n.phase != PH_IDLE);
        res.done_res   = done;
        res.status     = n.last_status;
    end

endmodule

`default_nettype wire
